FILE: rtl/epm_pkg.sv
// ----------------------------------------------------------------------------
// epm_pkg
// Shared constants, command codes and types of the exact pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package epm_pkg;

  localparam int MAX_PAT  = 64;
  localparam int POS_BITS = 32;
  localparam int OUT_W    = 32;
  localparam int CHAR_W   = 8;
  localparam int CMD_W    = 2;
  localparam int LEN_W    = $clog2(MAX_PAT + 1);
  localparam int GROUP    = 8;
  localparam int NGRP     = (MAX_PAT + GROUP - 1) / GROUP;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2
  } cmd_t;

  // Control broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic pat_shift;
    logic txt_shift;
    logic clear;
    logic adv;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/exact_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// exact_pattern_matcher_top
// Streaming exact search for a stored byte pattern over a text stream.
// ----------------------------------------------------------------------------
// Usage: each input word carries a command and a byte. Clear empties the
// pattern and restarts the text position at zero. Append adds a byte to the
// pattern (ignored once MAX_PAT bytes are held). Text feeds the next text
// byte; when the newest pattern-length text bytes equal the pattern, one
// result word carries the zero-based start of that occurrence. Overlapping
// occurrences are all reported, in increasing order. The position counter
// saturates at its maximum.
// Throughput is one input word per cycle while the output is not stalled.
// A result passes from the text registers to the hit flags of the comparator
// row, then through the grouped AND stage and the final AND into the output
// register. When the receiver stalls, the result word holds and the whole
// pipeline, including in_ready, stops until it is taken. Reset empties the
// pattern, zeroes the position and drops any word in flight; it takes effect
// at the first rising clock edge with rst_n low.
// ----------------------------------------------------------------------------
`default_nettype none

module exact_pattern_matcher_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [epm_pkg::CMD_W-1:0]  in_command,
  input  wire logic [epm_pkg::CHAR_W-1:0] in_char_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [epm_pkg::OUT_W-1:0]       out_match_start
);
  import epm_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [LEN_W-1:0]    LEN_MAX = LEN_W'(MAX_PAT);

  logic                adv;
  logic                acc;
  cell_ctl_t           ctl;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [POS_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;

  logic                s0_v_r;
  logic [POS_BITS-1:0] s0_cnt_r;
  logic [LEN_W-1:0]    s0_len_r;
  logic                s1_v_r;
  logic [OUT_W-1:0]    s1_start_r;
  logic                s2_v_r;
  logic [OUT_W-1:0]    s2_start_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_start_r;
  logic [POS_BITS-1:0] s0_diff;

  char_t               pat_q [MAX_PAT];
  char_t               txt_q [MAX_PAT];
  logic [MAX_PAT-1:0]  vld_q;
  logic [MAX_PAT-1:0]  hits;
  logic [NGRP-1:0]     grp_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && adv;

  assign cnt_inc = (cnt_r == POS_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    ctl       = '0;
    ctl.adv   = adv;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    if (acc) begin
      unique case (in_command)
        CMD_CLEAR: begin
          ctl.clear = 1'b1;
          len_nxt   = '0;
          cnt_nxt   = '0;
        end
        CMD_APPEND: begin
          if (len_r != LEN_MAX) begin
            ctl.pat_shift = 1'b1;
            len_nxt       = len_r + 1'b1;
          end
        end
        CMD_TEXT: begin
          ctl.txt_shift = 1'b1;
          cnt_nxt       = cnt_inc;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cnt_r <= '0;
    end else begin
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Comparator row: cell 0 takes the incoming byte, each later cell takes
  // its neighbor's contents.
  genvar k;
  generate
    for (k = 0; k < MAX_PAT; k++) begin : g_cell
      if (k == 0) begin : g_head
        epm_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .ctl     (ctl),
          .pat_in  (in_char_value),
          .vld_in  (1'b1),
          .txt_in  (in_char_value),
          .pat_out (pat_q[k]),
          .vld_out (vld_q[k]),
          .txt_out (txt_q[k]),
          .hit_r   (hits[k])
        );
      end else begin : g_body
        epm_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .ctl     (ctl),
          .pat_in  (pat_q[k-1]),
          .vld_in  (vld_q[k-1]),
          .txt_in  (txt_q[k-1]),
          .pat_out (pat_q[k]),
          .vld_out (vld_q[k]),
          .txt_out (txt_q[k]),
          .hit_r   (hits[k])
        );
      end
    end
  endgenerate

  epm_and_tree u_and_tree (
    .clk   (clk),
    .adv   (adv),
    .hits  (hits),
    .grp_r (grp_r)
  );

  assign s0_diff = s0_cnt_r - POS_BITS'(s0_len_r);

  // Position pipeline, kept in step with the cell hits and the AND stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cnt_r    <= cnt_inc;
      s0_len_r    <= len_r;
      s1_start_r  <= OUT_W'(s0_diff);
      s2_start_r  <= s1_start_r;
      out_start_r <= s2_start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_v_r      <= acc && (in_command == CMD_TEXT);
      s1_v_r      <= s0_v_r && (s0_len_r != '0) && (s0_cnt_r >= POS_BITS'(s0_len_r));
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r && (&grp_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_start = out_start_r;

endmodule

`default_nettype wire

FILE: rtl/epm_cell.sv
// ----------------------------------------------------------------------------
// epm_cell
// One comparator cell: holds one pattern and one text byte, passes both to
// its neighbor on a shift and registers agreement; an empty cell agrees.
// ----------------------------------------------------------------------------
`default_nettype none

module epm_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire epm_pkg::cell_ctl_t ctl,
  input  wire epm_pkg::char_t    pat_in,
  input  wire logic              vld_in,
  input  wire epm_pkg::char_t    txt_in,
  output epm_pkg::char_t         pat_out,
  output logic                   vld_out,
  output epm_pkg::char_t         txt_out,
  output logic                   hit_r
);
  import epm_pkg::*;

  char_t pat_r;
  char_t txt_r;
  logic  vld_r;

  // The pattern is held newest byte first, so cell k always lines up with
  // the text byte that arrived k text bytes before the newest one.
  always_ff @(posedge clk) begin
    if (ctl.pat_shift) begin
      pat_r <= pat_in;
    end
    if (ctl.txt_shift) begin
      txt_r <= txt_in;
    end
    if (ctl.adv) begin
      hit_r <= !vld_r || (pat_r == txt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.pat_shift) begin
      vld_r <= vld_in;
    end
  end

  assign pat_out = pat_r;
  assign vld_out = vld_r;
  assign txt_out = txt_r;

endmodule

`default_nettype wire

FILE: rtl/epm_and_tree.sv
// ----------------------------------------------------------------------------
// epm_and_tree
// First level of the registered reduction: ANDs the cell hits in groups.
// ----------------------------------------------------------------------------
`default_nettype none

module epm_and_tree (
  input  wire logic                      clk,
  input  wire logic                      adv,
  input  wire logic [epm_pkg::MAX_PAT-1:0] hits,
  output logic [epm_pkg::NGRP-1:0]       grp_r
);
  import epm_pkg::*;

  logic [NGRP*GROUP-1:0] hit_pad;

  // Cells past the end of the row count as agreeing.
  always_comb begin
    hit_pad              = '1;
    hit_pad[MAX_PAT-1:0] = hits;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= &hit_pad[g*GROUP +: GROUP];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/epm_checker.sv
// ----------------------------------------------------------------------------
// epm_checker
// Port-level checks on the exact pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module epm_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [epm_pkg::OUT_W-1:0] out_match_start
);

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_start))
    else $error("result word changed while stalled");

  // A stalled result stops the input side too.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the result stage is stalled");

  // With no result pending, the block always takes a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with an empty result stage");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word survived reset");

endmodule

bind exact_pattern_matcher_top epm_checker u_epm_checker (.*);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the exact pattern matcher.
// ----------------------------------------------------------------------------
// A short directed list covers the empty pattern, the unused command, a
// clear, an append after text, too little text and overlapping hits.
// Random sequences follow. Each one builds a pattern, sometimes a full one
// with extra appends, then streams text mostly from a small alphabet with
// copies of the pattern planted in it. A bench-side matcher predicts every
// start position, and the monitor checks each result word in order. Both
// handshakes idle at random.
// ----------------------------------------------------------------------------

module tb_top;

  import epm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic             hold;
    logic [CMD_W-1:0] cmd;
    char_t            ch;
  } stim_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_command = CMD_CLEAR;
  char_t             in_char_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OUT_W-1:0]  out_match_start;

  stim_word_t        stim_words[$];
  logic [OUT_W-1:0]  expected_starts[$];
  int                mismatches = 0;
  int                useful_words = 0;
  logic              hold_next = 1'b0;
  int                send_gap = 0;
  int                send_calm = 0;
  int                recv_gap = 0;
  int                recv_calm = 0;

  // Bench copy of the matcher state.
  char_t                pat_store[MAX_PAT];
  logic [LEN_W-1:0]     pat_len = '0;
  char_t                text_hist[MAX_PAT];
  logic [POS_BITS-1:0]  text_pos = '0;

  exact_pattern_matcher_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_char_value   (in_char_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_start (out_match_start)
  );

  always #5 clk = ~clk;

  // Applies one accepted word to the bench state and reports whether the
  // newest text bytes now equal the pattern.
  function automatic logic predict_match(input logic [CMD_W-1:0] cmd, input char_t ch,
                                         output logic [OUT_W-1:0] start);
    logic hit;
    hit = 1'b0;
    start = '0;
    case (cmd)
      CMD_CLEAR: begin
        pat_len = '0;
        text_pos = '0;
        for (int i = 0; i < MAX_PAT; i++) text_hist[i] = '0;
      end
      CMD_APPEND: begin
        if (pat_len < MAX_PAT) begin
          pat_store[pat_len] = ch;
          pat_len++;
        end
      end
      CMD_TEXT: begin
        for (int i = 0; i < MAX_PAT - 1; i++) text_hist[i] = text_hist[i + 1];
        text_hist[MAX_PAT - 1] = ch;
        if (text_pos != '1) text_pos++;
        if (pat_len != 0 && text_pos >= pat_len) begin
          hit = 1'b1;
          for (int i = 0; i < pat_len; i++) begin
            if (pat_store[i] != text_hist[MAX_PAT - pat_len + i]) hit = 1'b0;
          end
        end
        if (hit) start = OUT_W'(text_pos - pat_len);
      end
      default: ;
    endcase
    return hit;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_word(input logic [CMD_W-1:0] cmd, input char_t ch);
    stim_word_t w;
    w.hold = hold_next;
    w.cmd  = cmd;
    w.ch   = ch;
    hold_next = 1'b0;
    stim_words = {stim_words, w};
    if (cmd != CMD_UNUSED) useful_words++;
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  // Driver: predicts each accepted word, then presents the next one.
  always @(posedge clk) begin
    logic [OUT_W-1:0] start;
    stim_word_t       w;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_command    <= CMD_CLEAR;
      in_char_value <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (predict_match(in_command, in_char_value, start)) begin
          expected_starts = {expected_starts, start};
        end
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stim_words.size() > 0 &&
                     !(stim_words[0].hold && expected_starts.size() > 0)) begin
          w = stim_words.pop_front();
          in_valid      <= 1'b1;
          in_command    <= w.cmd;
          in_char_value <= w.ch;
          send_gap = next_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest predicted start.
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_starts.size() == 0) begin
          note_mismatch($sformatf("unexpected result: match_start %0d", out_match_start));
        end else begin
          want = expected_starts.pop_front();
          if (out_match_start !== want) begin
            note_mismatch($sformatf("match_start mismatch: expected %0d, got %0d",
                                    want, out_match_start));
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = next_gap(recv_calm);
      end
    end
  end

  initial begin
    int    seq_idx;
    int    r;
    int    plen;
    int    tlen;
    int    emitted;
    char_t a0;
    char_t a1;
    char_t b;
    char_t seq_pat[$];

    for (int i = 0; i < MAX_PAT; i++) begin
      pat_store[i] = '0;
      text_hist[i] = '0;
    end

    // Text with no pattern held, then the unused command.
    push_word(CMD_TEXT, 8'hAA);
    push_word(CMD_UNUSED, 8'hFF);
    // The pattern grows after text has been seen; later text matches it twice.
    push_word(CMD_APPEND, 8'h00);
    push_word(CMD_APPEND, 8'hFF);
    push_word(CMD_TEXT, 8'h00);
    push_word(CMD_TEXT, 8'hFF);
    push_word(CMD_TEXT, 8'h00);
    push_word(CMD_TEXT, 8'hFF);
    // Clear restarts the position; too little text, then overlapping hits.
    push_word(CMD_CLEAR, 8'hFF);
    repeat (3) push_word(CMD_APPEND, 8'h5A);
    repeat (4) push_word(CMD_TEXT, 8'h5A);
    push_word(CMD_APPEND, 8'h5A);
    push_word(CMD_TEXT, 8'h5A);
    // A zero pattern must not match the zeroed window after a clear.
    push_word(CMD_CLEAR, 8'h00);
    push_word(CMD_APPEND, 8'h00);
    push_word(CMD_APPEND, 8'h00);
    push_word(CMD_TEXT, 8'h00);
    push_word(CMD_TEXT, 8'h00);
    push_word(CMD_TEXT, 8'h7F);

    useful_words = 0;
    seq_idx = 0;
    while (useful_words < 600) begin
      // Every sixth sequence waits until all results so far have come.
      hold_next = (seq_idx % 6 == 0);
      seq_idx++;
      seq_pat.delete();
      if ($urandom_range(0, 99) < 85) push_word(CMD_CLEAR, char_t'($urandom_range(0, 255)));

      r = $urandom_range(0, 99);
      if (r < 8) plen = $urandom_range(60, 68);
      else if (r < 12) plen = 0;
      else plen = $urandom_range(1, 4);

      a0 = char_t'($urandom_range(0, 255));
      a1 = ($urandom_range(0, 3) == 0) ? a0 : char_t'($urandom_range(0, 255));
      for (int j = 0; j < plen; j++) begin
        b = $urandom_range(0, 1) ? a1 : a0;
        if (seq_pat.size() < MAX_PAT) seq_pat = {seq_pat, b};
        push_word(CMD_APPEND, b);
      end

      tlen = (plen > 8) ? $urandom_range(plen + 10, 2 * plen + 10) : $urandom_range(4, 20);
      emitted = 0;
      while (emitted < tlen) begin
        r = $urandom_range(0, 99);
        if (r < 25 && seq_pat.size() > 0) begin
          foreach (seq_pat[k]) push_word(CMD_TEXT, seq_pat[k]);
          emitted += seq_pat.size();
        end else if (r < 29) begin
          push_word(CMD_UNUSED, char_t'($urandom_range(0, 255)));
        end else if (r < 35) begin
          push_word(CMD_TEXT, char_t'($urandom_range(0, 255)));
          emitted++;
        end else begin
          push_word(CMD_TEXT, $urandom_range(0, 1) ? a1 : a0);
          emitted++;
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_words.size() > 0 || in_valid) @(negedge clk);
    while (expected_starts.size() > 0) @(negedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0 && expected_starts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
